// ----- src/bzr_pkg.sv -----
// ----------------------------------------------------------------------------
// bzr_pkg
// shared constants and register map for the cubic bezier point evaluator
// ----------------------------------------------------------------------------
package bzr_pkg;

  // default geometry
  localparam int COORD_BITS_DEF  = 10;
  localparam int T_FRAC_BITS_DEF = 12;

  // configuration register map
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 4;

  // control points per curve
  localparam int NUM_PTS = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_P0_X = 4'd0,
    REG_P0_Y = 4'd1,
    REG_P1_X = 4'd2,
    REG_P1_Y = 4'd3,
    REG_P2_X = 4'd4,
    REG_P2_Y = 4'd5,
    REG_P3_X = 4'd6,
    REG_P3_Y = 4'd7
  } cfg_reg_t;

endpackage

// ----- src/cubic_bezier_point_eval.sv -----
// ----------------------------------------------------------------------------
// cubic_bezier_point_eval
// cubic bezier point evaluator, de casteljau form, fully pipelined
// ----------------------------------------------------------------------------
// The block takes one curve parameter t per item (unsigned Q1.T_FRAC_BITS,
// values above 1.0 clamp to 1.0) and returns the curve point of the four
// control points held in the configuration registers, truncated to whole
// pixels. It accepts one item every cycle unless back-pressure stalls the
// pipeline; each item passes the clamp stage, then one register stage for
// each of the three interpolation levels, the last being the output
// register. Each level does its lerps for both axes in parallel,
// twenty-four multipliers of (COORD_BITS+T_FRAC_BITS) by (T_FRAC_BITS+1) bits
// in all. Backpressure stalls stages one by one, so bubbles are squeezed out
// and nothing is lost or repeated. Control points are read live and must only
// be written while no item is in flight; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module cubic_bezier_point_eval #(
  parameter int COORD_BITS  = bzr_pkg::COORD_BITS_DEF,
  parameter int T_FRAC_BITS = bzr_pkg::T_FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // input items
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  input  logic [((T_FRAC_BITS+1+7)/8)*8-1:0]       in_tdata,   // t_value
  // result items
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  output logic [((2*COORD_BITS+7)/8)*8-1:0]        out_tdata,  // pixel_x, pixel_y
  // control point registers
  input  logic                                     cfg_we,
  input  logic [bzr_pkg::CFG_IDX_W-1:0]            cfg_addr,
  input  logic [COORD_BITS-1:0]                    cfg_wdata
);

  localparam int VW     = COORD_BITS + T_FRAC_BITS;
  localparam int TW     = T_FRAC_BITS + 1;
  localparam int OUT_W  = ((2*COORD_BITS+7)/8)*8;
  localparam int NP     = bzr_pkg::NUM_PTS;
  localparam logic [TW-1:0] T_ONE = TW'(1) << T_FRAC_BITS;

  // control points
  logic [COORD_BITS-1:0] ctrl_x [NP];
  logic [COORD_BITS-1:0] ctrl_y [NP];

  bzr_cfg_regs #(
    .COORD_BITS (COORD_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .ctrl_x    (ctrl_x),
    .ctrl_y    (ctrl_y)
  );

  // control points as fixed-point values
  logic [VW-1:0] a_x [NP];
  logic [VW-1:0] a_y [NP];

  always_comb begin
    for (int i = 0; i < NP; i++) begin
      a_x[i] = {ctrl_x[i], {T_FRAC_BITS{1'b0}}};
      a_y[i] = {ctrl_y[i], {T_FRAC_BITS{1'b0}}};
    end
  end

  // stage 0: clamp t and form 1 - t
  logic          v0_r;
  logic          v0_nxt;
  logic [TW-1:0] t_r;
  logic [TW-1:0] t_inv_r;
  logic [TW-1:0] t_in;
  logic [TW-1:0] t_sat;
  logic          l1_in_ready;
  logic          in_take;

  assign t_in      = in_tdata[TW-1:0];
  assign t_sat     = (t_in > T_ONE) ? T_ONE : t_in;
  assign in_tready = !v0_r || l1_in_ready;
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    v0_nxt = v0_r;
    if (in_tready) begin
      v0_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      t_r     <= t_sat;
      t_inv_r <= T_ONE - t_sat;
    end
  end

  // level 1: three points per axis
  logic          v1;
  logic          l2_in_ready;
  logic [TW-1:0] t1;
  logic [TW-1:0] t1_inv;
  logic [VW-1:0] b_x [NP-1];
  logic [VW-1:0] b_y [NP-1];

  bzr_lerp_stage #(
    .COORD_BITS  (COORD_BITS),
    .T_FRAC_BITS (T_FRAC_BITS),
    .N_OUT       (NP-1)
  ) u_lvl1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v0_r),
    .in_ready  (l1_in_ready),
    .in_t      (t_r),
    .in_t_inv  (t_inv_r),
    .in_x      (a_x),
    .in_y      (a_y),
    .out_valid (v1),
    .out_ready (l2_in_ready),
    .out_t     (t1),
    .out_t_inv (t1_inv),
    .out_x     (b_x),
    .out_y     (b_y)
  );

  // level 2: two points per axis
  logic          v2;
  logic          l3_in_ready;
  logic [TW-1:0] t2;
  logic [TW-1:0] t2_inv;
  logic [VW-1:0] d_x [NP-2];
  logic [VW-1:0] d_y [NP-2];

  bzr_lerp_stage #(
    .COORD_BITS  (COORD_BITS),
    .T_FRAC_BITS (T_FRAC_BITS),
    .N_OUT       (NP-2)
  ) u_lvl2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v1),
    .in_ready  (l2_in_ready),
    .in_t      (t1),
    .in_t_inv  (t1_inv),
    .in_x      (b_x),
    .in_y      (b_y),
    .out_valid (v2),
    .out_ready (l3_in_ready),
    .out_t     (t2),
    .out_t_inv (t2_inv),
    .out_x     (d_x),
    .out_y     (d_y)
  );

  // level 3: final point, doubles as the output register
  logic [VW-1:0] e_x [1];
  logic [VW-1:0] e_y [1];

  bzr_lerp_stage #(
    .COORD_BITS  (COORD_BITS),
    .T_FRAC_BITS (T_FRAC_BITS),
    .N_OUT       (1)
  ) u_lvl3 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v2),
    .in_ready  (l3_in_ready),
    .in_t      (t2),
    .in_t_inv  (t2_inv),
    .in_x      (d_x),
    .in_y      (d_y),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_t     (),
    .out_t_inv (),
    .out_x     (e_x),
    .out_y     (e_y)
  );

  // truncate to whole pixels, x in the low bits
  assign out_tdata = OUT_W'({e_y[0][T_FRAC_BITS +: COORD_BITS],
                             e_x[0][T_FRAC_BITS +: COORD_BITS]});

  // clamp stage keeps t and 1 - t consistent
  a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    v0_r |-> (t_r <= T_ONE))
    else $error("clamped t above one");

  a_t_sum: assert property (@(posedge clk) disable iff (!rst_n)
    v0_r |-> ((TW+1)'(t_r) + (TW+1)'(t_inv_r) == (TW+1)'(T_ONE)))
    else $error("t and 1 - t do not add up to one");

  a_t_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && (t_in > T_ONE)) |=> (t_r == T_ONE))
    else $error("t above one not clamped");

  a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> v0_r)
    else $error("accepted item missing from clamp stage");

endmodule

// ----- src/bzr_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// bzr_cfg_regs
// control point register file, written through a plain write port
// ----------------------------------------------------------------------------
module bzr_cfg_regs #(
  parameter int COORD_BITS = bzr_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bzr_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [COORD_BITS-1:0]          cfg_wdata,
  output logic [COORD_BITS-1:0]          ctrl_x [bzr_pkg::NUM_PTS],
  output logic [COORD_BITS-1:0]          ctrl_y [bzr_pkg::NUM_PTS]
);

  logic [COORD_BITS-1:0] px_r [bzr_pkg::NUM_PTS];
  logic [COORD_BITS-1:0] py_r [bzr_pkg::NUM_PTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bzr_pkg::NUM_PTS; i++) begin
        px_r[i] <= '0;
        py_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_addr)
        bzr_pkg::REG_P0_X: px_r[0] <= cfg_wdata;
        bzr_pkg::REG_P0_Y: py_r[0] <= cfg_wdata;
        bzr_pkg::REG_P1_X: px_r[1] <= cfg_wdata;
        bzr_pkg::REG_P1_Y: py_r[1] <= cfg_wdata;
        bzr_pkg::REG_P2_X: px_r[2] <= cfg_wdata;
        bzr_pkg::REG_P2_Y: py_r[2] <= cfg_wdata;
        bzr_pkg::REG_P3_X: px_r[3] <= cfg_wdata;
        bzr_pkg::REG_P3_Y: py_r[3] <= cfg_wdata;
        default: ;  // indexes past the map are dropped
      endcase
    end
  end

  assign ctrl_x = px_r;
  assign ctrl_y = py_r;

endmodule

// ----- src/bzr_lerp_stage.sv -----
// ----------------------------------------------------------------------------
// bzr_lerp_stage
// one de casteljau level: lerps between adjacent points, both axes, registered
// ----------------------------------------------------------------------------
module bzr_lerp_stage #(
  parameter int COORD_BITS  = bzr_pkg::COORD_BITS_DEF,
  parameter int T_FRAC_BITS = bzr_pkg::T_FRAC_BITS_DEF,
  parameter int N_OUT       = 3
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [T_FRAC_BITS:0]              in_t,
  input  logic [T_FRAC_BITS:0]              in_t_inv,
  input  logic [COORD_BITS+T_FRAC_BITS-1:0] in_x [N_OUT+1],
  input  logic [COORD_BITS+T_FRAC_BITS-1:0] in_y [N_OUT+1],
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [T_FRAC_BITS:0]              out_t,
  output logic [T_FRAC_BITS:0]              out_t_inv,
  output logic [COORD_BITS+T_FRAC_BITS-1:0] out_x [N_OUT],
  output logic [COORD_BITS+T_FRAC_BITS-1:0] out_y [N_OUT]
);

  localparam int VW = COORD_BITS + T_FRAC_BITS;  // value width
  localparam int TW = T_FRAC_BITS + 1;           // t width
  localparam int PW = VW + TW;                   // product width
  localparam int SW = PW + 1;                    // sum width

  logic          valid_r;
  logic          valid_nxt;
  logic [TW-1:0] t_r;
  logic [TW-1:0] t_inv_r;
  logic [VW-1:0] x_r   [N_OUT];
  logic [VW-1:0] y_r   [N_OUT];
  logic [VW-1:0] x_nxt [N_OUT];
  logic [VW-1:0] y_nxt [N_OUT];
  logic          load;

  assign in_ready = !valid_r || out_ready;
  assign load     = in_valid && in_ready;

  // a*(1-t) + b*t, then drop the fractional bits of t
  always_comb begin
    logic [SW-1:0] sx;
    logic [SW-1:0] sy;
    for (int i = 0; i < N_OUT; i++) begin
      sx = SW'(PW'(in_x[i]) * PW'(in_t_inv)) + SW'(PW'(in_x[i+1]) * PW'(in_t));
      sy = SW'(PW'(in_y[i]) * PW'(in_t_inv)) + SW'(PW'(in_y[i+1]) * PW'(in_t));
      x_nxt[i] = sx[T_FRAC_BITS +: VW];
      y_nxt[i] = sy[T_FRAC_BITS +: VW];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      t_r     <= in_t;
      t_inv_r <= in_t_inv;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_t     = t_r;
  assign out_t_inv = t_inv_r;
  assign out_x     = x_r;
  assign out_y     = y_r;

endmodule
